/* design/pm1_pkg.sv */
// Package for the PM1a fixed-hardware register block.
// Holds the mode, port offset and power action codes and the register bit masks.
// No dependencies; used by the interfaces and by the top level.
`default_nettype none

package pm1_pkg;

  typedef logic [1:0]  mode_t;
  typedef logic [3:0]  offset_t;
  typedef logic [31:0] word_t;
  typedef logic [1:0]  action_t;
  typedef logic [10:0] status_t;

  localparam mode_t MODE_READ   = 2'd0;
  localparam mode_t MODE_WRITE  = 2'd1;
  localparam mode_t MODE_SLPBTN = 2'd2;
  localparam mode_t MODE_PWRBTN = 2'd3;

  localparam offset_t OFS_SMI     = 4'd0;
  localparam offset_t OFS_CONTROL = 4'd1;
  localparam offset_t OFS_STATUS  = 4'd4;
  localparam offset_t OFS_ENABLE  = 4'd6;
  localparam offset_t OFS_RESET   = 4'd8;

  localparam action_t ACT_NONE     = 2'd0;
  localparam action_t ACT_SHUTDOWN = 2'd1;
  localparam action_t ACT_SUSPEND  = 2'd2;
  localparam action_t ACT_REBOOT   = 2'd3;

  localparam word_t CMD_ACPI_ENABLE  = 32'h0000_00F2;
  localparam word_t CMD_ACPI_DISABLE = 32'h0000_00F1;
  localparam word_t RESET_VALUE      = 32'h0000_0004;

  localparam logic [2:0] SLP_TYP_SHUTDOWN = 3'd7;
  localparam logic [2:0] SLP_TYP_SUSPEND  = 3'd6;
  localparam int         SLP_TYP_LSB      = 10;
  localparam int         SLP_EN_POS       = 13;

  localparam status_t EVT_GBL       = 11'h020;
  localparam status_t EVT_PWRBTN    = 11'h100;
  localparam status_t EVT_SLPBTN    = 11'h200;
  localparam status_t EVT_RTC       = 11'h400;
  localparam status_t EVT_SUPPORTED = EVT_GBL | EVT_PWRBTN | EVT_SLPBTN | EVT_RTC;

  localparam word_t WAKE_ADDRESS_RESET = 32'hFFFF_FFF0;

endpackage

`default_nettype wire

/* design/pm1_ifs.sv */
// Valid/ready channel interfaces for the PM1a register block.
// pm1_req_if carries one access or button event, pm1_rsp_if one result beat.
// Depends on pm1_pkg.
`default_nettype none

interface pm1_req_if;
  logic              valid;
  logic              ready;
  pm1_pkg::mode_t    mode;
  pm1_pkg::offset_t  port_offset;
  pm1_pkg::word_t    write_data;

  modport source (output valid, output mode, output port_offset, output write_data,
                  input ready);
  modport sink   (input valid, input mode, input port_offset, input write_data,
                  output ready);
endinterface

interface pm1_rsp_if;
  logic              valid;
  logic              ready;
  pm1_pkg::word_t    read_data;
  logic              sci_level;
  pm1_pkg::action_t  power_action;
  pm1_pkg::word_t    resume_address;
  logic              button_taken;

  modport source (output valid, output read_data, output sci_level, output power_action,
                  output resume_address, output button_taken, input ready);
  modport sink   (input valid, input read_data, input sci_level, input power_action,
                  input resume_address, input button_taken, output ready);
endinterface

`default_nettype wire

/* design/acpi_pm1_register_block_unit.sv */
// Top level of the PM1a fixed-hardware register block: SMI command, control,
// status, enable and reset ports plus sleep and power button events.
// Depends on pm1_pkg and the channel interfaces in pm1_ifs.sv.
//
//   channel   dir   beat contents
//   req       in    mode, port_offset, write_data
//   rsp       out   read_data, sci_level, power_action, resume_address, button_taken
//   cfg       in    wake_address (write enable and data, no read-back)
//
// For each accepted request beat the register state is updated at the accepting
// edge and the result is captured in the output register in that same edge.
// One beat per cycle is sustained while rsp takes each result; the output register
// lets a new beat in whenever it is empty or being drained in the same cycle.
// A stall on rsp holds the result and blocks req until the result is taken.
// Reset is synchronous; no clearing pass is needed.
`default_nettype none

module acpi_pm1_register_block_unit (
  input  wire                  clk,
  input  wire                  rst,
  pm1_req_if.sink              req,
  pm1_rsp_if.source            rsp,
  input  wire                  cfg_write_en,
  input  wire pm1_pkg::word_t  cfg_write_data
);
  import pm1_pkg::*;

  word_t   wake_address;
  logic    acpi_on, acpi_on_next;
  status_t event_status, event_status_next;
  word_t   event_enable, event_enable_next;
  logic    sci_line, sci_line_next;

  logic    out_valid;
  word_t   read_data, read_data_next;
  logic    sci_level;
  action_t power_action, power_action_next;
  word_t   resume_address, resume_address_next;
  logic    button_taken, button_taken_next;

  logic    accept;
  status_t btn_bit;
  status_t status_cleared;
  logic [2:0] slp_typ;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign slp_typ        = req.write_data[SLP_TYP_LSB +: 3];
  assign status_cleared = event_status & ~(req.write_data[10:0] & EVT_SUPPORTED);
  assign btn_bit        = (req.mode == MODE_SLPBTN) ? EVT_SLPBTN : EVT_PWRBTN;

  always_comb begin
    acpi_on_next        = acpi_on;
    event_status_next   = event_status;
    event_enable_next   = event_enable;
    sci_line_next       = sci_line;
    read_data_next      = '0;
    power_action_next   = ACT_NONE;
    resume_address_next = '0;
    button_taken_next   = 1'b0;

    unique case (req.mode)
      MODE_READ: begin
        case (req.port_offset)
          OFS_SMI:     read_data_next = '0;
          OFS_CONTROL: read_data_next = {31'd0, acpi_on};
          OFS_STATUS:  read_data_next = {21'd0, event_status};
          OFS_ENABLE:  read_data_next = event_enable;
          default:     read_data_next = '1;
        endcase
      end
      MODE_WRITE: begin
        case (req.port_offset)
          OFS_SMI: begin
            if (req.write_data == CMD_ACPI_ENABLE) begin
              acpi_on_next = 1'b1;
            end else if (req.write_data == CMD_ACPI_DISABLE) begin
              acpi_on_next = 1'b0;
            end
          end
          OFS_CONTROL: begin
            if (req.write_data[SLP_EN_POS]) begin
              if (slp_typ == SLP_TYP_SHUTDOWN) begin
                power_action_next = ACT_SHUTDOWN;
              end else if (slp_typ == SLP_TYP_SUSPEND) begin
                power_action_next   = ACT_SUSPEND;
                resume_address_next = wake_address;
              end
            end
          end
          OFS_STATUS: begin
            event_status_next = status_cleared;
            if ((status_cleared & event_enable[10:0]) == '0) begin
              sci_line_next = 1'b0;
            end
          end
          OFS_ENABLE: begin
            event_enable_next = req.write_data;
            if (acpi_on && ((event_status & req.write_data[10:0] & EVT_SUPPORTED) != '0)) begin
              sci_line_next = 1'b1;
            end
          end
          OFS_RESET: begin
            if (req.write_data == RESET_VALUE) begin
              power_action_next = ACT_REBOOT;
            end
          end
          default: begin
          end
        endcase
      end
      MODE_SLPBTN, MODE_PWRBTN: begin
        // A button is latched only with ACPI on and its enable bit set.
        if (acpi_on && ((event_enable[10:0] & btn_bit) != '0)) begin
          event_status_next = event_status | btn_bit;
          sci_line_next     = 1'b1;
          button_taken_next = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_address <= WAKE_ADDRESS_RESET;
      acpi_on      <= 1'b0;
      event_status <= '0;
      event_enable <= '0;
      sci_line     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        wake_address <= cfg_write_data;
      end
      if (accept) begin
        acpi_on      <= acpi_on_next;
        event_status <= event_status_next;
        event_enable <= event_enable_next;
        sci_line     <= sci_line_next;
        out_valid    <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data      <= read_data_next;
      sci_level      <= sci_line_next;
      power_action   <= power_action_next;
      resume_address <= resume_address_next;
      button_taken   <= button_taken_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.read_data      = read_data;
  assign rsp.sci_level      = sci_level;
  assign rsp.power_action   = power_action;
  assign rsp.resume_address = resume_address;
  assign rsp.button_taken   = button_taken;

`ifndef SYNTHESIS
  // With no status bit pending the interrupt line must be low.
  a_sci_needs_status: assert property (@(posedge clk) disable iff (rst)
    (event_status == '0) |-> !sci_line)
    else $error("SCI high with empty status");

  a_taken_raises_sci: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.button_taken) |-> rsp.sci_level)
    else $error("button taken without SCI");

  a_resume_only_suspend: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.power_action != ACT_SUSPEND)) |-> (rsp.resume_address == '0))
    else $error("resume address without suspend");

  a_unused_read_ones: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.mode == MODE_READ) && (req.port_offset != OFS_SMI) &&
     (req.port_offset != OFS_CONTROL) && (req.port_offset != OFS_STATUS) &&
     (req.port_offset != OFS_ENABLE)) |=> (rsp.read_data == '1))
    else $error("unused offset read not all ones");

  a_no_taken_when_off: assert property (@(posedge clk) disable iff (rst)
    (accept && !acpi_on) |=> !button_taken)
    else $error("button taken with ACPI off");
`endif

endmodule

`default_nettype wire
